// ----- rtl/core/gabc_pkg.sv -----
// ----------------------------------------------------------------------------
// gabc_pkg
// Shared types and codes for the grid access bounds checker: operation codes,
// decoded operation controls and configuration register indexes.
// ----------------------------------------------------------------------------
package gabc_pkg;

	typedef enum logic [1:0] {
		FN_ADVANCE = 2'd0,
		FN_CHECK   = 2'd1,
		FN_CLEAR   = 2'd2,
		FN_SETPOS  = 2'd3
	} func_t;

	// One-hot decode of the operation, handed to each axis slice
	typedef struct packed {
		logic advance;
		logic check;
		logic clear;
		logic load;
	} op_ctl_t;

	localparam int CFG_IDX_W = 3;
	localparam int CHECK_W   = 3;
	localparam int NUM_AXES  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_I    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CEIL_I     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_J    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CEIL_J     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_K    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CEIL_K     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_MASK = 3'd6;

	function automatic op_ctl_t decode_func(input func_t fn);
		op_ctl_t op;
		op = '0;
		case (fn)
			FN_ADVANCE: op.advance = 1'b1;
			FN_CHECK:   op.check   = 1'b1;
			FN_CLEAR:   op.clear   = 1'b1;
			FN_SETPOS:  op.load    = 1'b1;
			default:    op = '0;
		endcase
		return op;
	endfunction

endpackage

// ----- rtl/core/gabc_req_if.sv -----
// ----------------------------------------------------------------------------
// gabc_req_if
// Request channel: operation code and three signed offsets.
// ----------------------------------------------------------------------------
interface gabc_req_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    func;
	logic signed [COORD_WIDTH-1:0] off_i;
	logic signed [COORD_WIDTH-1:0] off_j;
	logic signed [COORD_WIDTH-1:0] off_k;

	modport source (output valid, func, off_i, off_j, off_k, input ready);
	modport sink (input valid, func, off_i, off_j, off_k, output ready);
endinterface

// ----- rtl/core/gabc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gabc_rsp_if
// Result channel: range flags, position and bounding box.
// ----------------------------------------------------------------------------
interface gabc_rsp_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic                          bad_i;
	logic                          bad_j;
	logic                          bad_k;
	logic signed [COORD_WIDTH-1:0] at_i;
	logic signed [COORD_WIDTH-1:0] at_j;
	logic signed [COORD_WIDTH-1:0] at_k;
	logic signed [COORD_WIDTH-1:0] box_lo_i;
	logic signed [COORD_WIDTH-1:0] box_lo_j;
	logic signed [COORD_WIDTH-1:0] box_lo_k;
	logic signed [COORD_WIDTH-1:0] box_hi_i;
	logic signed [COORD_WIDTH-1:0] box_hi_j;
	logic signed [COORD_WIDTH-1:0] box_hi_k;

	modport source (
		output valid, bad_i, bad_j, bad_k, at_i, at_j, at_k,
		box_lo_i, box_lo_j, box_lo_k, box_hi_i, box_hi_j, box_hi_k,
		input ready
	);
	modport sink (
		input valid, bad_i, bad_j, bad_k, at_i, at_j, at_k,
		box_lo_i, box_lo_j, box_lo_k, box_hi_i, box_hi_j, box_hi_k,
		output ready
	);
endinterface

// ----- rtl/core/gabc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// gabc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gabc_cfg_if #(
	parameter int COORD_WIDTH = 16
);
	logic                             valid;
	logic                             ready;
	logic [gabc_pkg::CFG_IDX_W-1:0]   index;
	logic [COORD_WIDTH-1:0]           data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/gabc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// gabc_cfg_regs
// Configuration register file: per-axis floor and ceiling, axis check mask.
// ----------------------------------------------------------------------------
module gabc_cfg_regs #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	gabc_cfg_if.sink                         cfg,
	output logic signed [COORD_WIDTH-1:0]    floor_c [gabc_pkg::NUM_AXES],
	output logic signed [COORD_WIDTH-1:0]    ceil_c  [gabc_pkg::NUM_AXES],
	output logic [gabc_pkg::CHECK_W-1:0]     check_mask
);
	import gabc_pkg::*;

	logic signed [COORD_WIDTH-1:0] floor_q [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] ceil_q  [NUM_AXES];
	logic [CHECK_W-1:0]            mask_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				floor_q[a] <= '0;
				ceil_q[a]  <= '0;
			end
			mask_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FLOOR_I:    floor_q[0] <= cfg.data;
				REG_CEIL_I:     ceil_q[0]  <= cfg.data;
				REG_FLOOR_J:    floor_q[1] <= cfg.data;
				REG_CEIL_J:     ceil_q[1]  <= cfg.data;
				REG_FLOOR_K:    floor_q[2] <= cfg.data;
				REG_CEIL_K:     ceil_q[2]  <= cfg.data;
				REG_CHECK_MASK: mask_q     <= cfg.data[CHECK_W-1:0];
				default: ; // unused index: drop the write
			endcase
		end
	end

	assign floor_c    = floor_q;
	assign ceil_c     = ceil_q;
	assign check_mask = mask_q;

endmodule

// ----- rtl/core/gabc_axis.sv -----
// ----------------------------------------------------------------------------
// gabc_axis
// One axis slice: next position, range flag and bounding box update.
// ----------------------------------------------------------------------------
module gabc_axis #(
	parameter int COORD_WIDTH = 16
) (
	input  gabc_pkg::op_ctl_t              op,
	input  logic                           chk_en,
	input  logic signed [COORD_WIDTH-1:0]  pos,
	input  logic signed [COORD_WIDTH-1:0]  off,
	input  logic signed [COORD_WIDTH-1:0]  lim_lo,
	input  logic signed [COORD_WIDTH-1:0]  lim_hi,
	input  logic signed [COORD_WIDTH-1:0]  box_lo,
	input  logic signed [COORD_WIDTH-1:0]  box_hi,
	output logic signed [COORD_WIDTH-1:0]  pos_nxt,
	output logic signed [COORD_WIDTH-1:0]  box_lo_nxt,
	output logic signed [COORD_WIDTH-1:0]  box_hi_nxt,
	output logic                           bad
);
	import gabc_pkg::*;

	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic signed [COORD_WIDTH:0]   acc;
	logic signed [COORD_WIDTH:0]   lo_x;
	logic signed [COORD_WIDTH:0]   hi_x;
	logic signed [COORD_WIDTH-1:0] sat_v;

	// Exact sum, one guard bit wide
	assign acc  = {pos[COORD_WIDTH-1], pos} + {off[COORD_WIDTH-1], off};
	assign lo_x = {lim_lo[COORD_WIDTH-1], lim_lo};
	assign hi_x = {lim_hi[COORD_WIDTH-1], lim_hi};

	always_comb begin
		if (acc[COORD_WIDTH] != acc[COORD_WIDTH-1]) begin
			sat_v = acc[COORD_WIDTH] ? CMIN : CMAX;
		end else begin
			sat_v = acc[COORD_WIDTH-1:0];
		end
	end

	assign bad = op.check & chk_en & ((acc < lo_x) | (acc > hi_x));

	always_comb begin
		pos_nxt = pos;
		if (op.advance) begin
			pos_nxt = acc[COORD_WIDTH-1:0];
		end else if (op.load) begin
			pos_nxt = off;
		end
	end

	always_comb begin
		box_lo_nxt = box_lo;
		box_hi_nxt = box_hi;
		if (op.clear) begin
			box_lo_nxt = CMAX;
			box_hi_nxt = CMIN;
		end else if (op.check) begin
			if (sat_v < box_lo) box_lo_nxt = sat_v;
			if (sat_v > box_hi) box_hi_nxt = sat_v;
		end
	end

endmodule

// ----- rtl/core/grid_access_bounds_checker.sv -----
// A transaction in stage 1 moves on when the result stage is free or draining.
// Throughput: one transaction per cycle while results drain; the two register
// stages run as a pipeline whose state (position, box) feedback closes within
// the result stage. Reset (arst_n low) zeroes position and all configuration
// registers and empties the box; both pipeline stages come out of reset empty.
// ----------------------------------------------------------------------------
// grid_access_bounds_checker
// Tracks a 3-D grid position and checks stencil accesses against a configured
// valid box, keeping a saturated bounding box of all checked accesses.
// ----------------------------------------------------------------------------
module grid_access_bounds_checker #(
	parameter int COORD_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	gabc_cfg_if.sink   cfg,
	gabc_req_if.sink   req,
	gabc_rsp_if.source rsp
);
	import gabc_pkg::*;

	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Configuration
	logic signed [COORD_WIDTH-1:0] floor_c [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] ceil_c  [NUM_AXES];
	logic [CHECK_W-1:0]            check_mask;

	// Stage 1: registered request
	logic                          valid_s1;
	func_t                         func_s1;
	logic signed [COORD_WIDTH-1:0] off_s1 [NUM_AXES];

	// Architectural state
	logic signed [COORD_WIDTH-1:0] pos_q    [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] box_lo_q [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] box_hi_q [NUM_AXES];

	// Stage 2: result register
	logic                          valid_s2;
	logic                          bad_s2    [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] at_s2     [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] box_lo_s2 [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] box_hi_s2 [NUM_AXES];

	// Next-state from the axis slices
	logic signed [COORD_WIDTH-1:0] pos_nxt    [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] box_lo_nxt [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] box_hi_nxt [NUM_AXES];
	logic                          bad_nxt    [NUM_AXES];

	op_ctl_t op_s1;
	logic    s2_load;
	logic    req_fire;

	gabc_cfg_regs #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.floor_c    (floor_c),
		.ceil_c     (ceil_c),
		.check_mask (check_mask)
	);

	// Stage 2 takes the stage 1 transaction whenever the result slot is free
	// or is being drained this cycle. Stage 1 refills in the same cycle, so
	// a new request lands every cycle while the result side keeps up.
	assign s2_load   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || s2_load;
	assign req_fire  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Payload: capture on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (req_fire) begin
			func_s1   <= func_t'(req.func);
			off_s1[0] <= req.off_i;
			off_s1[1] <= req.off_j;
			off_s1[2] <= req.off_k;
		end
	end

	assign op_s1 = decode_func(func_s1);

	// One slice per axis; all three see the same decoded operation
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		gabc_axis #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_axis (
			.op         (op_s1),
			.chk_en     (check_mask[a]),
			.pos        (pos_q[a]),
			.off        (off_s1[a]),
			.lim_lo     (floor_c[a]),
			.lim_hi     (ceil_c[a]),
			.box_lo     (box_lo_q[a]),
			.box_hi     (box_hi_q[a]),
			.pos_nxt    (pos_nxt[a]),
			.box_lo_nxt (box_lo_nxt[a]),
			.box_hi_nxt (box_hi_nxt[a]),
			.bad        (bad_nxt[a])
		);
	end

	// Advance state only when the transaction moves into the result stage,
	// so the next transaction in stage 1 sees the updated position and box.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				pos_q[a]    <= '0;
				box_lo_q[a] <= CMAX;
				box_hi_q[a] <= CMIN;
			end
		end else if (s2_load) begin
			pos_q    <= pos_nxt;
			box_lo_q <= box_lo_nxt;
			box_hi_q <= box_hi_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result payload: hold while the consumer stalls
	always_ff @(posedge clk) begin
		if (s2_load) begin
			bad_s2    <= bad_nxt;
			at_s2     <= pos_nxt;
			box_lo_s2 <= box_lo_nxt;
			box_hi_s2 <= box_hi_nxt;
		end
	end

	assign rsp.valid    = valid_s2;
	assign rsp.bad_i    = bad_s2[0];
	assign rsp.bad_j    = bad_s2[1];
	assign rsp.bad_k    = bad_s2[2];
	assign rsp.at_i     = at_s2[0];
	assign rsp.at_j     = at_s2[1];
	assign rsp.at_k     = at_s2[2];
	assign rsp.box_lo_i = box_lo_s2[0];
	assign rsp.box_lo_j = box_lo_s2[1];
	assign rsp.box_lo_k = box_lo_s2[2];
	assign rsp.box_hi_i = box_hi_s2[0];
	assign rsp.box_hi_j = box_hi_s2[1];
	assign rsp.box_hi_k = box_hi_s2[2];

`ifndef NO_ASSERTIONS
	// A full stage 1 that cannot drain must back-pressure the request side
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_load |-> !req.ready)
		else $error("request accepted while stage 1 is blocked");

	// A pending result always shows the live position state
	a_result_tracks_pos: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (rsp.at_i == pos_q[0]) && (rsp.at_j == pos_q[1])
			&& (rsp.at_k == pos_q[2]))
		else $error("result position diverged from position state");

	// Flags are only raised by a check transaction
	a_flags_only_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		s2_load && !op_s1.check |=> !rsp.bad_i && !rsp.bad_j && !rsp.bad_k)
		else $error("range flag set on a non-check transaction");

	// After a check the box holds at least one point on every axis
	a_box_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		s2_load && op_s1.check |=> (box_lo_q[0] <= box_hi_q[0])
			&& (box_lo_q[1] <= box_hi_q[1]) && (box_lo_q[2] <= box_hi_q[2]))
		else $error("bounding box empty after a check");

	// Clearing the box restores the empty markers
	a_clear_empties_box: assert property (@(posedge clk) disable iff (!arst_n)
		s2_load && op_s1.clear |=> (box_lo_q[0] == CMAX) && (box_hi_q[0] == CMIN))
		else $error("box not emptied by clear");
`endif

endmodule

// ----- test/grid_access_bounds_checker_tb.sv -----
// ----------------------------------------------------------------------------
// grid_access_bounds_checker_tb
// Self-checking bench for the grid access bounds checker: drives requests and
// register writes over the channel interfaces, predicts position, range flags
// and bounding box per transaction, and checks every result in order.
// ----------------------------------------------------------------------------
module grid_access_bounds_checker_tb;
	import gabc_pkg::*;

	localparam int CW = 16;
	localparam longint CO_MAX_L = (longint'(1) << (CW - 1)) - 1;
	localparam longint CO_MIN_L = -CO_MAX_L - 1;
	localparam logic [CW-1:0] CO_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] CO_MIN = {1'b1, {(CW - 1){1'b0}}};
	// Index 7 has no register behind it; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 212;

	// One result transaction; packed arrays are indexed by axis (0 = i)
	typedef struct packed {
		logic [2:0]         bad;
		logic [2:0][CW-1:0] at;
		logic [2:0][CW-1:0] lo;
		logic [2:0][CW-1:0] hi;
	} grid_result_t;

	// Tracks position, box and window settings; holds predicted results in order
	class access_scoreboard;
		logic signed [CW-1:0] pos [3];
		logic signed [CW-1:0] box_lo [3];
		logic signed [CW-1:0] box_hi [3];
		logic signed [CW-1:0] win_lo [3];
		logic signed [CW-1:0] win_hi [3];
		logic [2:0] mask;
		grid_result_t pending [$];
		int errors;
		int checked;
		int fn_count [4];
		int flag_count;

		function new();
			for (int a = 0; a < 3; a++) begin
				pos[a] = '0;
				win_lo[a] = '0;
				win_hi[a] = '0;
				box_lo[a] = CO_MAX;
				box_hi[a] = CO_MIN;
			end
			mask = '0;
			errors = 0;
			checked = 0;
			flag_count = 0;
			for (int f = 0; f < 4; f++)
				fn_count[f] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] value);
			case (idx)
				REG_FLOOR_I:    win_lo[0] = value;
				REG_CEIL_I:     win_hi[0] = value;
				REG_FLOOR_J:    win_lo[1] = value;
				REG_CEIL_J:     win_hi[1] = value;
				REG_FLOOR_K:    win_lo[2] = value;
				REG_CEIL_K:     win_hi[2] = value;
				REG_CHECK_MASK: mask = value[CHECK_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(func_t fn, logic signed [CW-1:0] di,
				logic signed [CW-1:0] dj, logic signed [CW-1:0] dk);
			logic signed [CW-1:0] off [3];
			grid_result_t r;
			longint sum;
			longint clipped;
			off[0] = di;
			off[1] = dj;
			off[2] = dk;
			r = '0;
			for (int a = 0; a < 3; a++) begin
				case (fn)
					FN_ADVANCE: pos[a] = pos[a] + off[a];
					FN_CHECK: begin
						// exact sum for the flag, saturated sum for the box
						sum = longint'(pos[a]) + longint'(off[a]);
						if (mask[a] && (sum < longint'(win_lo[a]) || sum > longint'(win_hi[a])))
							r.bad[a] = 1'b1;
						clipped = (sum > CO_MAX_L) ? CO_MAX_L : (sum < CO_MIN_L) ? CO_MIN_L : sum;
						if (clipped < box_lo[a])
							box_lo[a] = clipped[CW-1:0];
						if (clipped > box_hi[a])
							box_hi[a] = clipped[CW-1:0];
					end
					FN_CLEAR: begin
						box_lo[a] = CO_MAX;
						box_hi[a] = CO_MIN;
					end
					FN_SETPOS: pos[a] = off[a];
					default: ;
				endcase
				r.at[a] = pos[a];
				r.lo[a] = box_lo[a];
				r.hi[a] = box_hi[a];
			end
			fn_count[int'(fn)]++;
			flag_count += $countones(r.bad);
			pending.push_back(r);
		endfunction

		function string axis_tag(int a);
			return (a == 0) ? "i" : (a == 1) ? "j" : "k";
		endfunction

		function void field_check(string name, logic [CW-1:0] want, logic [CW-1:0] got);
			if (want !== got) begin
				if (errors < 10)
					$display("mismatch in result %0d, %s: expected 0x%h, got 0x%h",
						checked, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(grid_result_t got);
			grid_result_t want;
			if (pending.size() == 0) begin
				if (errors < 10)
					$display("result with nothing outstanding: 0x%h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int a = 0; a < 3; a++) begin
				field_check({"bad_", axis_tag(a)}, CW'(want.bad[a]), CW'(got.bad[a]));
				field_check({"at_", axis_tag(a)}, want.at[a], got.at[a]);
				field_check({"box_lo_", axis_tag(a)}, want.lo[a], got.lo[a]);
				field_check({"box_hi_", axis_tag(a)}, want.hi[a], got.hi[a]);
			end
			checked++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gabc_cfg_if #(.COORD_WIDTH(CW)) cfg_bus ();
	gabc_req_if #(.COORD_WIDTH(CW)) req_bus ();
	gabc_rsp_if #(.COORD_WIDTH(CW)) rsp_bus ();

	grid_access_bounds_checker #(.COORD_WIDTH(CW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	access_scoreboard sb;
	// Idle switches for both sides; cleared for stretches of full-rate traffic
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	// Long receiver hold-off requested by the stimulus, consumed by the sink
	int hold_off_cycles = 0;
	int cfg_writes = 0;
	int settings = 0;
	int cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: end the run if the traffic never completes
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("== FAIL ==");
		$finish;
	end

	// Offer one request transaction. Valid stays high from the previous item
	// when no gap is drawn, so back-to-back items never toggle valid in one step.
	task automatic send_req(func_t fn, logic [CW-1:0] di, logic [CW-1:0] dj,
			logic [CW-1:0] dk);
		int gap;
		gap = src_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.func <= fn;
		req_bus.off_i <= di;
		req_bus.off_j <= dj;
		req_bus.off_k <= dk;
		do @(posedge clk); while (!req_bus.ready);
		sb.note_request(fn, di, dj, dk);
	endtask

	// Write one register; the caller drops cfg valid after its group of writes
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.write_reg(idx, value);
		cfg_writes++;
	endtask

	// Drop request valid and hold until every predicted result has come back,
	// then let the pipeline settle before anything touches the registers.
	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_IDX_W-1:0] floor_reg(int a);
		return (a == 0) ? REG_FLOOR_I : (a == 1) ? REG_FLOOR_J : REG_FLOOR_K;
	endfunction

	function automatic logic [CFG_IDX_W-1:0] ceil_reg(int a);
		return (a == 0) ? REG_CEIL_I : (a == 1) ? REG_CEIL_J : REG_CEIL_K;
	endfunction

	// Mostly small coordinates so accesses land around the windows, with
	// some full-range values and the two extremes
	function automatic logic [CW-1:0] rand_coord();
		logic [CW-1:0] v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 1) ? CO_MAX : CO_MIN;
			1, 2: v = CW'($urandom);
			default: v = CW'($urandom_range(0, 64) - 32);
		endcase
		return v;
	endfunction

	function automatic func_t rand_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return FN_CHECK;
		else if (r < 72)
			return FN_ADVANCE;
		else if (r < 92)
			return FN_SETPOS;
		return FN_CLEAR;
	endfunction

	// Program all windows and the mask. Phase 0 opens the full range, phase 1
	// inverts it (floor at max, ceiling at min), phase 2 pins each axis to a
	// single extreme value; later phases use small random windows, some with
	// the floor above the ceiling.
	task automatic random_config(int phase);
		logic [CW-1:0] lo;
		logic [CW-1:0] hi;
		logic [CW-1:0] mask_word;
		for (int a = 0; a < 3; a++) begin
			case (phase)
				0: begin
					lo = CO_MIN;
					hi = CO_MAX;
				end
				1: begin
					lo = CO_MAX;
					hi = CO_MIN;
				end
				2: begin
					lo = $urandom_range(0, 1) ? CO_MAX : CO_MIN;
					hi = lo;
				end
				default: begin
					lo = CW'($urandom_range(0, 80) - 40);
					hi = lo + CW'($urandom_range(0, 40) - 4);
				end
			endcase
			cfg_write(floor_reg(a), lo);
			cfg_write(ceil_reg(a), hi);
		end
		// Random upper bits on the mask word; only the low three count
		mask_word = CW'($urandom);
		if (phase < 2)
			mask_word[2:0] = 3'b111;
		cfg_write(REG_CHECK_MASK, mask_word);
		if ($urandom_range(0, 1))
			cfg_write(REG_UNMAPPED, CW'($urandom));
		cfg_bus.valid <= 1'b0;
		settings++;
	endtask

	// Result sink: draw a stall per transaction, or take a long hold-off when
	// the stimulus asks for one, then accept and check the next result.
	initial begin : result_sink
		int stall;
		grid_result_t got;
		rsp_bus.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				stall = snk_idle ? $urandom_range(0, 14) : 0;
			end
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
			got.bad = {rsp_bus.bad_k, rsp_bus.bad_j, rsp_bus.bad_i};
			got.at = {rsp_bus.at_k, rsp_bus.at_j, rsp_bus.at_i};
			got.lo = {rsp_bus.box_lo_k, rsp_bus.box_lo_j, rsp_bus.box_lo_i};
			got.hi = {rsp_bus.box_hi_k, rsp_bus.box_hi_j, rsp_bus.box_hi_i};
			sb.check_result(got);
		end
	end

	initial begin : stimulus
		sb = new();
		req_bus.valid <= 1'b0;
		req_bus.func <= FN_ADVANCE;
		req_bus.off_i <= '0;
		req_bus.off_j <= '0;
		req_bus.off_k <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_FLOOR_I;
		cfg_bus.data <= '0;

		// Hold reset, then release on a rising edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: zero position, empty box, nothing checked
		send_req(FN_ADVANCE, CW'(0), CW'(0), CW'(0));
		send_req(FN_CHECK, CW'(5), CW'(-5), CW'(0));
		wait_idle();

		// Small windows on i and j, k with its floor above its ceiling, all
		// axes checked; a write to the unmapped index must be ignored
		cfg_write(REG_FLOOR_I, CW'(-10));
		cfg_write(REG_CEIL_I, CW'(10));
		cfg_write(REG_FLOOR_J, CW'(-5));
		cfg_write(REG_CEIL_J, CW'(5));
		cfg_write(REG_FLOOR_K, CW'(3));
		cfg_write(REG_CEIL_K, CW'(-3));
		cfg_write(REG_CHECK_MASK, CW'(7));
		cfg_write(REG_UNMAPPED, 16'hffff);
		cfg_bus.valid <= 1'b0;
		settings++;

		send_req(FN_CLEAR, CW'(0), CW'(0), CW'(0));
		send_req(FN_SETPOS, CW'(100), CW'(-100), CW'(0));
		send_req(FN_CHECK, CW'(-90), CW'(95), CW'(0));
		send_req(FN_CHECK, CW'(-111), CW'(106), CW'(1));
		// Accesses past the coordinate range: flag on exact sum, box saturates
		send_req(FN_SETPOS, CO_MAX, CO_MIN, CO_MAX);
		send_req(FN_CHECK, CO_MAX, CO_MIN, CW'(1));
		// Advance wraps around the coordinate width
		send_req(FN_ADVANCE, CW'(1), CW'(-1), CW'(1));
		send_req(FN_CHECK, CO_MIN, CO_MAX, CO_MIN);
		send_req(FN_CLEAR, 16'h5a5a, 16'ha5a5, 16'hffff);
		send_req(FN_SETPOS, CW'(0), CW'(0), CW'(0));
		// Inclusive window edges
		send_req(FN_CHECK, CW'(10), CW'(-5), CW'(0));
		send_req(FN_CHECK, CW'(-10), CW'(5), CW'(-3));
		wait_idle();

		// Disabled j axis: no flag, box still widens; full range on i
		cfg_write(REG_FLOOR_I, CO_MIN);
		cfg_write(REG_CEIL_I, CO_MAX);
		cfg_write(REG_CHECK_MASK, 16'hfff5);
		cfg_bus.valid <= 1'b0;
		settings++;

		send_req(FN_CHECK, CW'(11), CW'(6), CW'(0));
		send_req(FN_CHECK, CO_MIN, CW'(100), CW'(3));
		send_req(FN_ADVANCE, CO_MAX, CO_MIN, CO_MAX);
		send_req(FN_CHECK, CO_MAX, CO_MAX, CO_MIN);
		wait_idle();

		// Random phases, each with its own register setting
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			random_config(phase);
			if (phase == 3) begin
				// Stall the sink for a long stretch while the source keeps
				// offering back to back, so the pipeline fills and backs up
				hold_off_cycles = 400;
				src_idle = 1'b0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Redraw idle switches now and then for stretches of full rate
				if (n % 40 == 0 && !(phase == 3 && n < 80)) begin
					src_idle = $urandom_range(0, 2) != 0;
					snk_idle = $urandom_range(0, 2) != 0;
				end
				send_req(rand_func(), rand_coord(), rand_coord(), rand_coord());
			end
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d transactions: %0d advance, %0d check, %0d clear, %0d set-position",
			sb.checked, sb.fn_count[FN_ADVANCE], sb.fn_count[FN_CHECK],
			sb.fn_count[FN_CLEAR], sb.fn_count[FN_SETPOS]);
		$display("%0d out-of-range flags, %0d register writes over %0d settings, %0d errors",
			sb.flag_count, cfg_writes, settings, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
